// File: rtl/dtlsdmx_pkg.sv
// ----------------------------------------------------------------------------
// dtlsdmx_pkg
// Shared types and constants for the DTLS/RTP packet demultiplexer.
// ----------------------------------------------------------------------------
package dtlsdmx_pkg;

   localparam int unsigned DataWidth    = 8;
   localparam int unsigned LengthWidth  = 16;
   localparam int unsigned OffsetWidth  = 17;
   localparam int unsigned VerdictWidth = 4;
   localparam int unsigned StateWidth   = 2;

   // record header layout and packet thresholds
   localparam logic [LengthWidth-1:0] HdrLen     = 16'd13;
   localparam logic [LengthWidth-1:0] HelloMin   = 16'd17;
   localparam logic [LengthWidth-1:0] RtpMin     = 16'd12;
   localparam logic [LengthWidth-1:0] LenHiPos   = 16'd11;
   localparam logic [LengthWidth-1:0] LenLoPos   = 16'd12;
   localparam logic [LengthWidth-1:0] HsTypePos  = 16'd13;
   localparam logic [LengthWidth-1:0] LengthMax  = 16'hFFFF;
   localparam logic [OffsetWidth-1:0] OffsetMax  = 17'h1FFFF;

   localparam logic [DataWidth-1:0] DtlsLow       = 8'd19;
   localparam logic [DataWidth-1:0] DtlsHigh      = 8'd64;
   localparam logic [DataWidth-1:0] HandshakeType = 8'd22;
   localparam logic [DataWidth-1:0] ClientHello   = 8'd1;
   localparam logic [DataWidth-1:0] RtpMask       = 8'hC0;
   localparam logic [DataWidth-1:0] RtpVersion    = 8'h80;

   typedef enum logic [StateWidth-1:0] {
      LINK_NEW        = 2'd0,
      LINK_CONNECTING = 2'd1,
      LINK_CONNECTED  = 2'd2,
      LINK_CLOSED     = 2'd3
   } link_state_type;

   typedef enum logic [VerdictWidth-1:0] {
      VERDICT_CACHE_HELLO   = 4'd0,
      VERDICT_DROP_NO_HELLO = 4'd1,
      VERDICT_TO_DTLS       = 4'd2,
      VERDICT_BAD_RECORDS   = 4'd3,
      VERDICT_EARLY_MEDIA   = 4'd4,
      VERDICT_NOT_RTP       = 4'd5,
      VERDICT_FORWARD_RTP   = 4'd6,
      VERDICT_INACTIVE      = 4'd7,
      VERDICT_OVERSIZE      = 4'd8
   } verdict_type;

   typedef struct packed {
      verdict_type            verdict;
      logic [LengthWidth-1:0] packet_length;
   } result_type;

endpackage

// File: rtl/dtlsdmx_track.sv
// ----------------------------------------------------------------------------
// dtlsdmx_track
// Per-packet tracker: byte count, record chain walk and final verdict.
// ----------------------------------------------------------------------------
module dtlsdmx_track (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  advance,
   input  logic [dtlsdmx_pkg::DataWidth-1:0]     data_byte,
   input  logic                                  last_byte,
   input  dtlsdmx_pkg::link_state_type           link_state,
   output logic                                  result_valid,
   output dtlsdmx_pkg::result_type               result
);

   logic [dtlsdmx_pkg::LengthWidth-1:0] byte_index_ff, byte_index_in;
   logic [dtlsdmx_pkg::OffsetWidth-1:0] next_offset_ff, next_offset_in;
   logic [dtlsdmx_pkg::DataWidth-1:0]   length_high_ff, length_high_in;
   logic [dtlsdmx_pkg::DataWidth-1:0]   first_byte_ff, first_byte_in;
   logic [dtlsdmx_pkg::DataWidth-1:0]   hs_type_ff, hs_type_in;
   logic                                too_long_ff, too_long_in;

   logic [dtlsdmx_pkg::OffsetWidth:0]   pos_ext;
   logic [dtlsdmx_pkg::OffsetWidth:0]   len_hi_at;
   logic [dtlsdmx_pkg::OffsetWidth:0]   len_lo_at;
   logic [dtlsdmx_pkg::OffsetWidth:0]   chain_sum;
   logic [dtlsdmx_pkg::LengthWidth-1:0] pkt_len;
   logic                                tl;
   logic                                walk;
   logic                                is_dtls;
   logic                                is_hello;
   logic                                is_rtp;
   logic                                chain_ok;
   dtlsdmx_pkg::verdict_type            verdict;

   always_comb begin
      tl      = too_long_ff | (byte_index_ff == dtlsdmx_pkg::LengthMax);
      pos_ext = {2'b00, byte_index_ff};
      len_hi_at = {1'b0, next_offset_ff} + {2'b00, dtlsdmx_pkg::LenHiPos};
      len_lo_at = {1'b0, next_offset_ff} + {2'b00, dtlsdmx_pkg::LenLoPos};
      chain_sum = {1'b0, next_offset_ff} + {2'b00, dtlsdmx_pkg::HdrLen}
                  + {2'b00, length_high_ff, data_byte};
      // a saturated offset stops the walk
      walk = !tl && (next_offset_ff != dtlsdmx_pkg::OffsetMax);

      too_long_in    = tl;
      byte_index_in  = tl ? byte_index_ff : byte_index_ff + 16'd1;
      first_byte_in  = (!tl && byte_index_ff == '0) ? data_byte : first_byte_ff;
      hs_type_in     = (!tl && byte_index_ff == dtlsdmx_pkg::HsTypePos)
                       ? data_byte : hs_type_ff;
      length_high_in = length_high_ff;
      next_offset_in = next_offset_ff;
      if (walk && pos_ext == len_hi_at) begin
         length_high_in = data_byte;
      end else if (walk && pos_ext == len_lo_at) begin
         next_offset_in = chain_sum[dtlsdmx_pkg::OffsetWidth]
                          ? dtlsdmx_pkg::OffsetMax
                          : chain_sum[dtlsdmx_pkg::OffsetWidth-1:0];
      end
   end

   // classification on the final byte
   always_comb begin
      pkt_len  = byte_index_ff + 16'd1;
      is_dtls  = (pkt_len >= dtlsdmx_pkg::HdrLen) && (first_byte_in > dtlsdmx_pkg::DtlsLow)
                 && (first_byte_in < dtlsdmx_pkg::DtlsHigh);
      is_hello = is_dtls && (pkt_len > dtlsdmx_pkg::HelloMin)
                 && (first_byte_in == dtlsdmx_pkg::HandshakeType)
                 && (hs_type_in == dtlsdmx_pkg::ClientHello);
      is_rtp   = (pkt_len >= dtlsdmx_pkg::RtpMin)
                 && ((first_byte_in & dtlsdmx_pkg::RtpMask) == dtlsdmx_pkg::RtpVersion);
      chain_ok = (next_offset_in == {1'b0, pkt_len});

      if (tl) begin
         verdict = dtlsdmx_pkg::VERDICT_OVERSIZE;
      end else begin
         case (link_state)
            dtlsdmx_pkg::LINK_NEW: begin
               verdict = is_hello ? dtlsdmx_pkg::VERDICT_CACHE_HELLO
                                  : dtlsdmx_pkg::VERDICT_DROP_NO_HELLO;
            end
            dtlsdmx_pkg::LINK_CLOSED: begin
               verdict = dtlsdmx_pkg::VERDICT_INACTIVE;
            end
            dtlsdmx_pkg::LINK_CONNECTING: begin
               if (is_dtls) begin
                  verdict = chain_ok ? dtlsdmx_pkg::VERDICT_TO_DTLS
                                     : dtlsdmx_pkg::VERDICT_BAD_RECORDS;
               end else begin
                  verdict = dtlsdmx_pkg::VERDICT_EARLY_MEDIA;
               end
            end
            default: begin
               if (is_dtls) begin
                  verdict = chain_ok ? dtlsdmx_pkg::VERDICT_TO_DTLS
                                     : dtlsdmx_pkg::VERDICT_BAD_RECORDS;
               end else begin
                  verdict = is_rtp ? dtlsdmx_pkg::VERDICT_FORWARD_RTP
                                   : dtlsdmx_pkg::VERDICT_NOT_RTP;
               end
            end
         endcase
      end

      result_valid         = advance && last_byte;
      result.verdict       = verdict;
      result.packet_length = tl ? dtlsdmx_pkg::LengthMax : pkt_len;
   end

   always_ff @(posedge clock) begin
      if (reset || (advance && last_byte)) begin
         byte_index_ff  <= '0;
         next_offset_ff <= '0;
         length_high_ff <= '0;
         first_byte_ff  <= '0;
         hs_type_ff     <= '0;
         too_long_ff    <= 1'b0;
      end else if (advance) begin
         byte_index_ff  <= byte_index_in;
         next_offset_ff <= next_offset_in;
         length_high_ff <= length_high_in;
         first_byte_ff  <= first_byte_in;
         hs_type_ff     <= hs_type_in;
         too_long_ff    <= too_long_in;
      end
   end

endmodule

// File: rtl/dtlsdmx_out_reg.sv
// ----------------------------------------------------------------------------
// dtlsdmx_out_reg
// Result register holding one verdict until the consumer takes it.
// ----------------------------------------------------------------------------
module dtlsdmx_out_reg (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  dtlsdmx_pkg::result_type load_result,
   input  logic                    rsp_stall,
   output logic                    rsp_valid,
   output logic                    can_load,
   output dtlsdmx_pkg::result_type rsp_result
);

   logic                    valid_ff, valid_in;
   dtlsdmx_pkg::result_type result_ff;

   assign can_load   = !valid_ff || !rsp_stall;
   assign valid_in   = load || (valid_ff && rsp_stall);
   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= load_result;
      end
   end

endmodule

// File: rtl/dtls_rtp_packet_demux_core.sv
// ----------------------------------------------------------------------------
// dtls_rtp_packet_demux_core
// Byte-serial DTLS/RTP demultiplexer: one verdict per received UDP payload.
// ----------------------------------------------------------------------------
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  req     | req_valid req_stall req_data_byte       | in
//          | req_last_byte                           |
//  rsp     | rsp_valid rsp_stall rsp_verdict         | out
//          | rsp_packet_length                       |
//  csr     | csr_valid csr_ready csr_link_state      | in
//
//  one byte transfer per cycle sustained while no last byte is held back by a
//  rsp stall; rsp_valid for a packet rises once its last byte has passed the
//  input register and then the tracker into the result register
//  reset is synchronous, active high; link state resets to new
//  a rsp stall only holds back a last byte, other bytes keep flowing
//  csr writes are always taken; the link state is sampled at the last byte
// ----------------------------------------------------------------------------
module dtls_rtp_packet_demux_core (
   input  logic                                     clock,
   input  logic                                     reset,
   // byte input
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic [dtlsdmx_pkg::DataWidth-1:0]        req_data_byte,
   input  logic                                     req_last_byte,
   // verdict output
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic [dtlsdmx_pkg::VerdictWidth-1:0]     rsp_verdict,
   output logic [dtlsdmx_pkg::LengthWidth-1:0]      rsp_packet_length,
   // link state register
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [dtlsdmx_pkg::StateWidth-1:0]       csr_link_state
);

   // input register
   logic                                in_valid_ff, in_valid_in;
   logic [dtlsdmx_pkg::DataWidth-1:0]   in_byte_ff;
   logic                                in_last_ff;

   dtlsdmx_pkg::link_state_type         link_state_ff;

   logic                                advance;
   logic                                out_can_load;
   logic                                trk_valid;
   dtlsdmx_pkg::result_type             trk_result;
   dtlsdmx_pkg::result_type             out_result;

   // non-final bytes never need the result register
   assign advance     = in_valid_ff && (!in_last_ff || out_can_load);
   assign req_stall   = in_valid_ff && !advance;
   assign in_valid_in = (req_valid && !req_stall) || (in_valid_ff && !advance);
   assign csr_ready   = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // payload loads on each input transfer
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_state_ff <= dtlsdmx_pkg::LINK_NEW;
      end else if (csr_valid && csr_ready) begin
         link_state_ff <= dtlsdmx_pkg::link_state_type'(csr_link_state);
      end
   end

   dtlsdmx_track u_track (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .data_byte    (in_byte_ff),
      .last_byte    (in_last_ff),
      .link_state   (link_state_ff),
      .result_valid (trk_valid),
      .result       (trk_result)
   );

   dtlsdmx_out_reg u_out_reg (
      .clock       (clock),
      .reset       (reset),
      .load        (trk_valid),
      .load_result (trk_result),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .can_load    (out_can_load),
      .rsp_result  (out_result)
   );

   assign rsp_verdict       = out_result.verdict;
   assign rsp_packet_length = out_result.packet_length;

endmodule

// File: sim/tb_dtls_rtp_packet_demux_core.sv
// ----------------------------------------------------------------------------
// tb_dtls_rtp_packet_demux_core
// Self-checking bench: UDP payloads go in byte by byte, and each verdict is
// checked against a byte-level tracker of the packet classifier, under all
// four link states and three idling patterns.
// ----------------------------------------------------------------------------
module tb_dtls_rtp_packet_demux_core;

   localparam int unsigned DataWidth    = dtlsdmx_pkg::DataWidth;
   localparam int unsigned LengthWidth  = dtlsdmx_pkg::LengthWidth;
   localparam int unsigned OffsetWidth  = dtlsdmx_pkg::OffsetWidth;
   localparam int unsigned VerdictWidth = dtlsdmx_pkg::VerdictWidth;
   localparam int unsigned StateWidth   = dtlsdmx_pkg::StateWidth;

   // no transfer of any kind for this many cycles means the block hung
   localparam int unsigned HangLimit = 2000;
   // verdict is valid once the last byte has passed the input and result registers; leave some slack
   localparam int unsigned DrainCycles = 8;

   typedef struct packed {
      logic [DataWidth-1:0] data;
      logic                 last;
   } byte_xfer_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [DataWidth-1:0]    req_data_byte = '0;
   logic                    req_last_byte = 1'b0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [VerdictWidth-1:0] rsp_verdict;
   logic [LengthWidth-1:0]  rsp_packet_length;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [StateWidth-1:0]   csr_link_state = '0;

   dtls_rtp_packet_demux_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_last_byte     (req_last_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_verdict       (rsp_verdict),
      .rsp_packet_length (rsp_packet_length),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_link_state    (csr_link_state)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // bytes waiting to be sent, and verdicts waiting to come out
   byte_xfer_type            bytes_to_send[$];
   dtlsdmx_pkg::result_type  verdicts_due[$];
   logic [DataWidth-1:0]     pkt[$];            // packet under construction
   int unsigned              queued_bytes = 0;
   int unsigned              fail_count = 0;
   int unsigned              send_idle_pct = 0;
   int unsigned              recv_idle_pct = 0;

   // first bytes right at the DTLS and RTP class edges
   logic [DataWidth-1:0] class_edges[12] = '{
      8'd19, 8'd20, 8'd63, 8'd64, 8'h7F, 8'h80, 8'hBF, 8'hC0, 8'h3F, 8'h40, 8'h00, 8'hFF
   };

   // --------------------------------------------------------------------------
   // classifier tracker: the block's packet state, mirrored per byte
   // --------------------------------------------------------------------------
   dtlsdmx_pkg::link_state_type link_now = dtlsdmx_pkg::LINK_NEW;
   logic [LengthWidth-1:0] trk_index = '0;
   logic [OffsetWidth-1:0] trk_next_hdr = '0;
   logic [DataWidth-1:0]   trk_len_hi = '0;
   logic [DataWidth-1:0]   trk_first = '0;
   logic [DataWidth-1:0]   trk_hs_type = '0;
   logic                   trk_oversize = 1'b0;

   function automatic void clear_tracker();
      trk_index    = '0;
      trk_next_hdr = '0;
      trk_len_hi   = '0;
      trk_first    = '0;
      trk_hs_type  = '0;
      trk_oversize = 1'b0;
   endfunction

   // takes one accepted byte; on a last byte it hands back the verdict due
   task automatic track_byte(input logic [DataWidth-1:0] b, input logic last,
                             output logic done, output dtlsdmx_pkg::result_type res);
      int unsigned pos, nx, n;
      logic        is_dtls, is_hello, is_rtp, chain_ok;
      pos  = trk_index;
      done = 1'b0;
      res  = '0;
      // a byte at position 65535 or later marks the packet oversize for good
      if (pos >= 65535) trk_oversize = 1'b1;
      if (!trk_oversize) begin
         if (pos == 0) trk_first = b;
         if (pos == 13) trk_hs_type = b;
         // a saturated header offset stops the record walk
         if (trk_next_hdr < dtlsdmx_pkg::OffsetMax) begin
            if (pos == trk_next_hdr + 11) begin
               trk_len_hi = b;
            end else if (pos == trk_next_hdr + 12) begin
               nx = trk_next_hdr + 13 + {trk_len_hi, b};
               trk_next_hdr = (nx > dtlsdmx_pkg::OffsetMax) ? dtlsdmx_pkg::OffsetMax
                                                           : OffsetWidth'(nx);
            end
         end
         trk_index = LengthWidth'(pos + 1);
      end
      if (last) begin
         done = 1'b1;
         if (trk_oversize) begin
            res.verdict       = dtlsdmx_pkg::VERDICT_OVERSIZE;
            res.packet_length = dtlsdmx_pkg::LengthMax;
         end else begin
            n        = pos + 1;
            is_dtls  = n >= 13 && trk_first > dtlsdmx_pkg::DtlsLow
                       && trk_first < dtlsdmx_pkg::DtlsHigh;
            is_hello = is_dtls && n > 17 && trk_first == dtlsdmx_pkg::HandshakeType
                       && trk_hs_type == dtlsdmx_pkg::ClientHello;
            is_rtp   = n >= 12
                       && (trk_first & dtlsdmx_pkg::RtpMask) == dtlsdmx_pkg::RtpVersion;
            // chain is good only when the next header would start at the end
            chain_ok = trk_next_hdr == n;
            case (link_now)
               dtlsdmx_pkg::LINK_NEW: begin
                  res.verdict = is_hello ? dtlsdmx_pkg::VERDICT_CACHE_HELLO
                                         : dtlsdmx_pkg::VERDICT_DROP_NO_HELLO;
               end
               dtlsdmx_pkg::LINK_CLOSED: begin
                  res.verdict = dtlsdmx_pkg::VERDICT_INACTIVE;
               end
               default: begin
                  if (is_dtls)
                     res.verdict = chain_ok ? dtlsdmx_pkg::VERDICT_TO_DTLS
                                            : dtlsdmx_pkg::VERDICT_BAD_RECORDS;
                  else if (link_now != dtlsdmx_pkg::LINK_CONNECTED)
                     res.verdict = dtlsdmx_pkg::VERDICT_EARLY_MEDIA;
                  else
                     res.verdict = is_rtp ? dtlsdmx_pkg::VERDICT_FORWARD_RTP
                                          : dtlsdmx_pkg::VERDICT_NOT_RTP;
               end
            endcase
            res.packet_length = LengthWidth'(n);
         end
         clear_tracker();
      end
   endtask

   // --------------------------------------------------------------------------
   // byte driver: next byte goes out once the current one has transferred
   // --------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (bytes_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_valid     <= 1'b1;
            req_data_byte <= bytes_to_send[0].data;
            req_last_byte <= bytes_to_send[0].last;
            void'(bytes_to_send.pop_front());
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver back-pressure; only a last byte actually waits on it
   always @(posedge clock) begin
      rsp_stall <= !reset && ($urandom_range(0, 99) < recv_idle_pct);
   end

   // --------------------------------------------------------------------------
   // monitor: verdict check first, then the new byte into the tracker
   // --------------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      logic                    got;
      dtlsdmx_pkg::result_type want, fresh;
      if (reset) begin
         link_now = dtlsdmx_pkg::LINK_NEW;
         clear_tracker();
      end else begin
         // link state model follows every write to the register
         if (csr_valid && csr_ready)
            link_now = dtlsdmx_pkg::link_state_type'(csr_link_state);
         if (rsp_valid && !rsp_stall) begin
            if (verdicts_due.size() == 0) begin
               $error("verdict %0d length %0d with no packet pending",
                      rsp_verdict, rsp_packet_length);
               fail_count++;
            end else begin
               want = verdicts_due.pop_front();
               if (rsp_verdict !== want.verdict) begin
                  $error("verdict: expected %0d, got %0d", want.verdict, rsp_verdict);
                  fail_count++;
               end
               if (rsp_packet_length !== want.packet_length) begin
                  $error("packet_length: expected %0d, got %0d",
                         want.packet_length, rsp_packet_length);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            track_byte(req_data_byte, req_last_byte, got, fresh);
            if (got) verdicts_due.push_back(fresh);
         end
      end
   end

   // hang detection: any transfer on any channel restarts the count
   always @(posedge clock) begin : watchdog
      int unsigned quiet;
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         quiet = 0;
      end else begin
         quiet++;
         if (quiet >= HangLimit) begin
            $display("tb_dtls_rtp_packet_demux_core failed");
            $finish;
         end
      end
   end

   // --------------------------------------------------------------------------
   // packet building
   // --------------------------------------------------------------------------
   task automatic add_random(input int unsigned count);
      repeat (count) pkt.push_back(DataWidth'($urandom));
   endtask

   // one record: content type, ten bytes of version/epoch/sequence, length,
   // then the body; hs >= 0 forces the first body byte (handshake type)
   task automatic add_record(input logic [DataWidth-1:0] ct, input int unsigned body,
                             input int hs);
      logic [15:0] len;
      len = 16'(body);
      pkt.push_back(ct);
      add_random(10);
      pkt.push_back(len[15:8]);
      pkt.push_back(len[7:0]);
      if (body != 0) begin
         pkt.push_back(hs >= 0 ? DataWidth'(hs) : DataWidth'($urandom));
         add_random(body - 1);
      end
   endtask

   task automatic close_packet();
      foreach (pkt[i]) bytes_to_send.push_back('{data: pkt[i], last: i == pkt.size() - 1});
      queued_bytes += pkt.size();
      pkt.delete();
   endtask

   task automatic queue_random_packet();
      int unsigned kind, nrec, body, cut;
      logic [DataWidth-1:0] first;
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
         // record chain, well formed below 30, then damaged
         first = $urandom_range(0, 1) ? dtlsdmx_pkg::HandshakeType
                                      : DataWidth'($urandom_range(20, 63));
         nrec  = $urandom_range(1, 3);
         for (int r = 0; r < nrec; r++) begin
            body = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
            add_record(r == 0 ? first : DataWidth'($urandom_range(20, 63)), body,
                       $urandom_range(0, 1) ? dtlsdmx_pkg::ClientHello : -1);
         end
         if (kind >= 30) begin
            if ($urandom_range(0, 1)) begin
               cut = $urandom_range(1, 12);
               repeat (cut) void'(pkt.pop_back());
            end else begin
               add_random($urandom_range(1, 4));
            end
         end
      end else if (kind < 65) begin
         // rtp-looking, length straddling the 12-byte minimum
         pkt.push_back({2'b10, 6'($urandom)});
         add_random($urandom_range(8, 30));
      end else if (kind < 80) begin
         pkt.push_back(class_edges[$urandom_range(0, 11)]);
         add_random($urandom_range(0, 19));
      end else begin
         add_random($urandom_range(1, 24));
      end
      close_packet();
   endtask

   // hand-picked packets for the cases each link state cares about
   task automatic queue_directed(input dtlsdmx_pkg::link_state_type s);
      case (s)
         dtlsdmx_pkg::LINK_NEW: begin
            // smallest hello
            add_record(dtlsdmx_pkg::HandshakeType, 5, dtlsdmx_pkg::ClientHello);
            close_packet();
            // hello one byte too short
            add_record(dtlsdmx_pkg::HandshakeType, 4, dtlsdmx_pkg::ClientHello);
            close_packet();
            add_record(dtlsdmx_pkg::HandshakeType, 5, 2);  // handshake but not a hello
            close_packet();
            add_record(8'd23, 5, dtlsdmx_pkg::ClientHello); // hello byte, wrong record type
            close_packet();
            pkt.push_back(8'h00);                       // single byte packet
            close_packet();
         end
         dtlsdmx_pkg::LINK_CONNECTING: begin
            add_record(8'd20, 0, -1);                   // empty record then a body
            add_record(8'd21, 3, -1);
            close_packet();
            add_record(8'd63, 6, -1);                   // ends inside the next header
            add_random(5);
            close_packet();
            add_record(8'd63, 6, -1);                   // ends inside the body
            void'(pkt.pop_back());
            close_packet();
            pkt.push_back(8'd19);                       // just below the dtls range
            add_random(12);
            close_packet();
            pkt.push_back(8'h80);                       // media before connected
            add_random(11);
            close_packet();
         end
         dtlsdmx_pkg::LINK_CONNECTED: begin
            add_record(8'd20, 0, -1);                   // bare 13-byte header
            close_packet();
            pkt.push_back(8'h80);                       // shortest rtp
            add_random(11);
            close_packet();
            pkt.push_back(8'hBF);                       // rtp one byte short
            add_random(10);
            close_packet();
            pkt.push_back(8'hC0);                       // wrong rtp version
            add_random(11);
            close_packet();
            pkt.push_back(8'd64);                       // just above the dtls range
            repeat (12) pkt.push_back(8'hFF);
            close_packet();
            pkt.push_back(8'd22);                       // huge length, short packet
            add_random(10);
            pkt.push_back(8'hFF);
            pkt.push_back(8'h00);
            add_random(5);
            close_packet();
         end
         default: begin
            add_record(dtlsdmx_pkg::HandshakeType, 9, dtlsdmx_pkg::ClientHello);
            close_packet();
            pkt.push_back(8'h80);
            add_random(20);
            close_packet();
         end
      endcase
   endtask

   // idle means all bytes sent, every verdict in, and the pipeline flushed
   task automatic wait_idle();
      @(negedge clock);
      while (bytes_to_send.size() != 0 || req_valid || verdicts_due.size() != 0)
         @(negedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_link_state(input dtlsdmx_pkg::link_state_type s);
      @(posedge clock);
      csr_valid      <= 1'b1;
      csr_link_state <= s;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // --------------------------------------------------------------------------
   // run: twelve phases, each state once under each idling pattern
   // --------------------------------------------------------------------------
   initial begin : stimulus
      dtlsdmx_pkg::link_state_type order[12];
      int unsigned                 start;
      order = '{dtlsdmx_pkg::LINK_NEW, dtlsdmx_pkg::LINK_CONNECTING,
                dtlsdmx_pkg::LINK_CONNECTED, dtlsdmx_pkg::LINK_CLOSED,
                dtlsdmx_pkg::LINK_CLOSED, dtlsdmx_pkg::LINK_CONNECTED,
                dtlsdmx_pkg::LINK_CONNECTING, dtlsdmx_pkg::LINK_NEW,
                dtlsdmx_pkg::LINK_CONNECTING, dtlsdmx_pkg::LINK_NEW,
                dtlsdmx_pkg::LINK_CLOSED, dtlsdmx_pkg::LINK_CONNECTED};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      for (int phase = 0; phase < 12; phase++) begin
         wait_idle();
         case (phase / 4)
            0: begin
               send_idle_pct <= 15;
               recv_idle_pct <= 53;
            end
            1: begin
               send_idle_pct <= 53;
               recv_idle_pct <= 15;
            end
            default: begin
               send_idle_pct <= 0;
               recv_idle_pct <= 0;
            end
         endcase
         write_link_state(order[phase]);
         @(negedge clock);
         start = queued_bytes;
         if (phase < 4) queue_directed(order[phase]);
         // top up with random packets
         while (queued_bytes - start < 20) queue_random_packet();
      end
      wait_idle();
      if (fail_count == 0) begin
         $display("tb_dtls_rtp_packet_demux_core passed");
      end else begin
         $display("tb_dtls_rtp_packet_demux_core failed");
      end
      $finish;
   end

endmodule
